// ===== design/rtc_pkg.sv =====
// Shared types, codes and the leap-year rule for the calendar counter.
package rtc_pkg;

  // Command codes
  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_ADVANCE = 2'd1;
  localparam logic [1:0] CMD_SET     = 2'd2;

  // Field limits
  localparam logic [5:0] SEC_LIMIT  = 6'd60;
  localparam logic [6:0] MIN_LIMIT  = 7'd60;
  localparam logic [6:0] HOUR_LIMIT = 7'd24;

  // Day-after-last-day marks, compared against the incremented day
  localparam logic [5:0] DAY_END_LONG     = 6'd32;
  localparam logic [5:0] DAY_END_SHORT    = 6'd31;
  localparam logic [5:0] DAY_END_FEB_LEAP = 6'd30;
  localparam logic [5:0] DAY_END_FEB      = 6'd29;

  localparam logic [3:0] MONTH_JAN  = 4'd1;
  localparam logic [3:0] MONTH_FEB  = 4'd2;
  localparam logic [3:0] MONTH_APR  = 4'd4;
  localparam logic [3:0] MONTH_JUN  = 4'd6;
  localparam logic [3:0] MONTH_SEP  = 4'd9;
  localparam logic [3:0] MONTH_NOV  = 4'd11;
  localparam logic [3:0] MONTH_OVER = 4'd13;
  localparam logic [3:0] MONTH_LAST = 4'd12;
  localparam logic [4:0] DAY_FIRST  = 5'd1;
  localparam logic [4:0] DAY_LAST   = 5'd31;

  // Years below 256 that are multiples of 100; zero is also a multiple of 400
  localparam logic [7:0] YEAR_CENT_1 = 8'd100;
  localparam logic [7:0] YEAR_CENT_2 = 8'd200;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] hour_tens_char;
    logic [7:0] hour_ones_char;
    logic [7:0] minute_tens_char;
    logic [7:0] minute_ones_char;
  } in_word_t;

  typedef struct packed {
    logic [5:0] second_count;
    logic [6:0] minute_count;
    logic [6:0] hour_count;
    logic [4:0] day_of_month;
    logic [3:0] month_number;
    logic [7:0] year_count;
    logic       leap_flag;
    logic       set_accepted;
  } out_word_t;

  typedef struct packed {
    logic [5:0] sec;
    logic [6:0] min;
    logic [6:0] hour;
    logic [4:0] day;
    logic [3:0] month;
    logic [7:0] year;
    logic       leap;
  } rtc_time_t;

  localparam rtc_time_t RTC_RESET = '{
    sec: 6'd0, min: 7'd0, hour: 7'd0, day: DAY_FIRST, month: MONTH_JAN,
    year: 8'd0, leap: 1'b1
  };

  // Gregorian rule restricted to an 8-bit count: only zero is a multiple of 400
  function automatic logic leap_of(input logic [7:0] y);
    leap_of = (y == 8'd0) ||
              ((y[1:0] == 2'b00) && (y != YEAR_CENT_1) && (y != YEAR_CENT_2));
  endfunction

endpackage

// ===== design/rtc_calendar_counter.sv =====
// Top level of the clock and calendar counter: input register, state and result register.
//
//   channel | direction | handshake            | word
//   in_     | input     | in_valid / in_ready  | in_word_t  (command and digits)
//   out_    | output    | out_valid / out_ready| out_word_t (time, date, set status)
//
// One word a cycle while the result is not stalled: a command enters the input register,
// and on advance the step logic updates the time state and the result register together.
// out_valid rises when the input register advances; the step logic is combinational.
// Reset (synchronous, rst_n low) empties both registers and sets 00:00:00, day 1,
// month 1, year 0, leap set.
// A stalled result holds the input register; in_ready drops only when both are full.
module rtc_calendar_counter import rtc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  logic      s1_valid_r;
  in_word_t  s1_word_r;
  rtc_time_t state_r;
  rtc_time_t state_nxt;
  logic      set_ok;
  logic      out_valid_r;
  out_word_t out_word_r;
  logic      advance;

  rtc_step u_step (
    .cur    (state_r),
    .word   (s1_word_r),
    .nxt    (state_nxt),
    .set_ok (set_ok)
  );

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= RTC_RESET;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_word_r <= in_data;
    end
    if (advance) begin
      out_word_r.second_count <= state_nxt.sec;
      out_word_r.minute_count <= state_nxt.min;
      out_word_r.hour_count   <= state_nxt.hour;
      out_word_r.day_of_month <= state_nxt.day;
      out_word_r.month_number <= state_nxt.month;
      out_word_r.year_count   <= state_nxt.year;
      out_word_r.leap_flag    <= state_nxt.leap;
      out_word_r.set_accepted <= set_ok;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

endmodule

// ===== design/rtc_step.sv =====
// Next-state logic for one command: time set, tick or advance, and the carry chain.
module rtc_step import rtc_pkg::*; (
  input  rtc_time_t cur,
  input  in_word_t  word,
  output rtc_time_t nxt,
  output logic      set_ok
);

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic [6:0] two_digits(input logic [7:0] tc, input logic [7:0] oc);
    logic [3:0] t;
    logic [3:0] o;
    t = 4'(tc - CHAR_ZERO);
    o = 4'(oc - CHAR_ZERO);
    two_digits = {t, 3'b000} + {2'b00, t, 1'b0} + {3'b000, o};
  endfunction

  logic       digits_ok;
  logic       roll;
  rtc_time_t  pre;
  logic       sec_wrap;
  logic       min_wrap;
  logic       hour_wrap;
  logic [5:0] day_inc;
  logic       short_month;
  logic       is_feb;
  logic       month_end;
  logic [3:0] month_inc;

  assign digits_ok = is_digit(word.hour_tens_char) && is_digit(word.hour_ones_char) &&
                     is_digit(word.minute_tens_char) && is_digit(word.minute_ones_char);

  // Apply the command itself
  always_comb begin
    pre    = cur;
    roll   = 1'b0;
    set_ok = 1'b0;
    case (word.cmd)
      CMD_TICK: begin
        pre.sec = cur.sec + 6'd1;
        roll    = 1'b1;
      end
      CMD_ADVANCE: begin
        pre.min = cur.min + 7'd1;
        roll    = 1'b1;
      end
      CMD_SET: begin
        if (digits_ok) begin
          pre.hour = two_digits(word.hour_tens_char, word.hour_ones_char);
          pre.min  = two_digits(word.minute_tens_char, word.minute_ones_char);
          set_ok   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign short_month = (pre.month == MONTH_APR) || (pre.month == MONTH_JUN) ||
                       (pre.month == MONTH_SEP) || (pre.month == MONTH_NOV);
  assign is_feb      = (pre.month == MONTH_FEB);
  assign day_inc     = {1'b0, pre.day} + 6'd1;
  assign month_end   = (day_inc == DAY_END_LONG) ||
                       ((day_inc == DAY_END_SHORT) && short_month) ||
                       ((day_inc == DAY_END_FEB_LEAP) && is_feb && pre.leap) ||
                       ((day_inc == DAY_END_FEB) && is_feb && !pre.leap);
  assign month_inc   = pre.month + 4'd1;

  // Carry chain, each stage at most once
  always_comb begin
    nxt       = pre;
    sec_wrap  = 1'b0;
    min_wrap  = 1'b0;
    hour_wrap = 1'b0;
    if (roll) begin
      sec_wrap = (pre.sec >= SEC_LIMIT);
      if (sec_wrap) begin
        nxt.sec = 6'd0;
        nxt.min = pre.min + 7'd1;
      end
      min_wrap = (nxt.min >= MIN_LIMIT);
      if (min_wrap) begin
        nxt.min  = 7'd0;
        nxt.hour = pre.hour + 7'd1;
      end
      hour_wrap = (nxt.hour >= HOUR_LIMIT);
      if (hour_wrap) begin
        nxt.hour = 7'd0;
        if (month_end) begin
          nxt.day = DAY_FIRST;
          if (month_inc == MONTH_OVER) begin
            nxt.month = MONTH_JAN;
            nxt.year  = pre.year + 8'd1;
            nxt.leap  = leap_of(pre.year + 8'd1);
          end else begin
            nxt.month = month_inc;
          end
        end else begin
          nxt.day = day_inc[4:0];
        end
      end
    end
  end

endmodule

// ===== design/rtc_checker.sv =====
// Port-level checks for the calendar counter, bound to the top level.
module rtc_checker import rtc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not empty after reset");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.second_count < SEC_LIMIT &&
                  out_data.day_of_month >= DAY_FIRST && out_data.day_of_month <= DAY_LAST &&
                  out_data.month_number >= MONTH_JAN && out_data.month_number <= MONTH_LAST)
    else $error("date or seconds out of range");

  a_leap_rule: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.leap_flag == leap_of(out_data.year_count))
    else $error("leap flag disagrees with year count");

  // A stalled input word holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input word changed while stalled");

endmodule

bind rtc_calendar_counter rtc_checker u_rtc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== dv/tb_top.sv =====
// Testbench for the clock and calendar counter: random traffic checked against a model.
`timescale 1ns / 100ps

module tb_top;
  import rtc_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned TOTAL_WORDS = 1500;
  localparam int unsigned DRAIN_LIMIT = 5000;

  class calendar_scoreboard;
    logic [5:0] sec;
    logic [6:0] min;
    logic [6:0] hour;
    logic [4:0] day;
    logic [3:0] month;
    logic [7:0] year;
    logic       leap;
    out_word_t  expected_readings[$];
    int unsigned mismatches;

    function new();
      sec = '0;
      min = '0;
      hour = '0;
      day = 5'd1;
      month = 4'd1;
      year = '0;
      leap = 1'b1;
      mismatches = 0;
    endfunction

    function bit is_ascii_digit(logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    // Each field carries at most once, in order from seconds to months.
    function void carry_fields();
      logic [5:0] next_day;
      bit short_month;
      bit month_done;
      int y;
      if (sec >= 6'd60) begin
        sec = '0;
        min = min + 1'b1;
      end
      if (min >= 7'd60) begin
        min = '0;
        hour = hour + 1'b1;
      end
      if (hour >= 7'd24) begin
        hour = '0;
        next_day = {1'b0, day} + 6'd1;
        short_month = (month == MONTH_APR) || (month == MONTH_JUN) ||
                      (month == MONTH_SEP) || (month == MONTH_NOV);
        month_done = (next_day == 6'd32) ||
                     (next_day == 6'd31 && short_month) ||
                     (next_day == 6'd30 && month == MONTH_FEB && leap) ||
                     (next_day == 6'd29 && month == MONTH_FEB && !leap);
        if (month_done) begin
          day = 5'd1;
          month = month + 1'b1;
          if (month == 4'd13) begin
            month = 4'd1;
            year = year + 1'b1;
            y = year;
            leap = ((y % 400) == 0) || (((y % 4) == 0) && ((y % 100) != 0));
          end
        end else begin
          day = next_day[4:0];
        end
      end
    endfunction

    function void note_command(in_word_t w);
      out_word_t r;
      bit loaded;
      loaded = 1'b0;
      case (w.cmd)
        CMD_TICK: begin
          sec = sec + 1'b1;
          carry_fields();
        end
        CMD_ADVANCE: begin
          min = min + 1'b1;
          carry_fields();
        end
        CMD_SET: begin
          if (is_ascii_digit(w.hour_tens_char) && is_ascii_digit(w.hour_ones_char) &&
              is_ascii_digit(w.minute_tens_char) && is_ascii_digit(w.minute_ones_char)) begin
            hour = 7'((w.hour_tens_char - CHAR_ZERO) * 10 + (w.hour_ones_char - CHAR_ZERO));
            min = 7'((w.minute_tens_char - CHAR_ZERO) * 10 +
                     (w.minute_ones_char - CHAR_ZERO));
            loaded = 1'b1;
          end
        end
        default: begin
        end
      endcase
      r.second_count = sec;
      r.minute_count = min;
      r.hour_count = hour;
      r.day_of_month = day;
      r.month_number = month;
      r.year_count = year;
      r.leap_flag = leap;
      r.set_accepted = loaded;
      expected_readings.push_back(r);
    endfunction

    function int unsigned pending();
      return expected_readings.size();
    endfunction

    function void report(string what, int unsigned want, int unsigned got);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0d got %0d", what, want, got);
    endfunction

    function void check_readout(out_word_t got);
      out_word_t want;
      if (expected_readings.size() == 0) begin
        report("unexpected word, pending count", 0, 1);
        return;
      end
      want = expected_readings.pop_front();
      if (got.second_count !== want.second_count)
        report("second_count", want.second_count, got.second_count);
      if (got.minute_count !== want.minute_count)
        report("minute_count", want.minute_count, got.minute_count);
      if (got.hour_count !== want.hour_count)
        report("hour_count", want.hour_count, got.hour_count);
      if (got.day_of_month !== want.day_of_month)
        report("day_of_month", want.day_of_month, got.day_of_month);
      if (got.month_number !== want.month_number)
        report("month_number", want.month_number, got.month_number);
      if (got.year_count !== want.year_count)
        report("year_count", want.year_count, got.year_count);
      if (got.leap_flag !== want.leap_flag)
        report("leap_flag", want.leap_flag, got.leap_flag);
      if (got.set_accepted !== want.set_accepted)
        report("set_accepted", want.set_accepted, got.set_accepted);
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  calendar_scoreboard sb;
  int unsigned words_sent = 0;
  bit sender_calm = 1'b0;

  rtc_calendar_counter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function logic [7:0] any_char();
    return 8'($urandom_range(0, 255));
  endfunction

  function logic [7:0] digit_char(int unsigned n);
    return CHAR_ZERO + 8'(n);
  endfunction

  function in_word_t make_word(logic [1:0] cmd, logic [7:0] ht, logic [7:0] ho,
                               logic [7:0] mt, logic [7:0] mo);
    in_word_t w;
    w.cmd = cmd;
    w.hour_tens_char = ht;
    w.hour_ones_char = ho;
    w.minute_tens_char = mt;
    w.minute_ones_char = mo;
    return w;
  endfunction

  function in_word_t set_word(int unsigned hh, int unsigned mm);
    return make_word(CMD_SET, digit_char(hh / 10), digit_char(hh % 10),
                     digit_char(mm / 10), digit_char(mm % 10));
  endfunction

  task automatic send_word(in_word_t w);
    int unsigned gap;
    gap = sender_calm ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_command(w);
    words_sent++;
    if (words_sent % 50 == 0) sender_calm = ($urandom_range(0, 3) == 0);
  endtask

  // Hold the input until every outstanding word has come back.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic send_directed();
    send_word(make_word(CMD_TICK, 8'h00, 8'h00, 8'h00, 8'h00));
    send_word(make_word(CMD_ADVANCE, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_word(make_word(CMD_UNUSED, 8'h00, 8'h00, 8'h00, 8'h00));
    send_word(make_word(CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_word(set_word(23, 59));
    send_word(make_word(CMD_ADVANCE, 8'h00, 8'h00, 8'h00, 8'h00));
    send_word(set_word(99, 99));
    send_word(make_word(CMD_TICK, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_word(make_word(CMD_ADVANCE, 8'h00, 8'h00, 8'h00, 8'h00));
    // reject: one non-digit character in each position, the first two just outside the digit range
    send_word(make_word(CMD_SET, 8'h2F, digit_char(1), digit_char(2), digit_char(3)));
    send_word(make_word(CMD_SET, digit_char(1), 8'h3A, digit_char(2), digit_char(3)));
    send_word(make_word(CMD_SET, digit_char(1), digit_char(2), 8'h00, digit_char(3)));
    send_word(make_word(CMD_SET, digit_char(1), digit_char(2), digit_char(3), 8'hFF));
    send_word(make_word(CMD_SET, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_word(set_word(0, 0));
    send_word(set_word(90, 9));
    send_word(set_word(24, 0));
    send_word(make_word(CMD_TICK, 8'h00, 8'h00, 8'h00, 8'h00));
  endtask

  task automatic send_random();
    int unsigned pick;
    int unsigned bad_pos;
    int unsigned next_drain;
    logic [7:0] c [4];
    next_drain = words_sent + 400;
    while (words_sent < TOTAL_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        // skip a day: 23:59, or hours at or over the limit, then a step command
        if ($urandom_range(0, 3) == 0) begin
          send_word(set_word(23, 59));
          send_word(make_word(CMD_ADVANCE, any_char(), any_char(), any_char(), any_char()));
        end else begin
          send_word(set_word($urandom_range(24, 99), $urandom_range(0, 99)));
          send_word(make_word($urandom_range(0, 1) ? CMD_TICK : CMD_ADVANCE,
                              any_char(), any_char(), any_char(), any_char()));
        end
      end else if (pick < 77) begin
        send_word(make_word(CMD_TICK, any_char(), any_char(), any_char(), any_char()));
      end else if (pick < 83) begin
        send_word(make_word(CMD_ADVANCE, any_char(), any_char(), any_char(), any_char()));
      end else if (pick < 87) begin
        send_word(set_word($urandom_range(0, 99), $urandom_range(0, 99)));
      end else if (pick < 95) begin
        send_word(make_word(2'($urandom_range(0, 3)), any_char(), any_char(), any_char(),
                            any_char()));
      end else if (pick < 98) begin
        for (int i = 0; i < 4; i++) c[i] = digit_char($urandom_range(0, 9));
        bad_pos = $urandom_range(0, 3);
        c[bad_pos] = $urandom_range(0, 1) ? 8'h2F : 8'h3A;
        send_word(make_word(CMD_SET, c[0], c[1], c[2], c[3]));
      end else begin
        // tick until the seconds wrap so the carry runs from seconds to the day
        send_word(set_word(23, 59));
        do begin
          send_word(make_word(CMD_TICK, any_char(), any_char(), any_char(), any_char()));
        end while (sb.sec != 6'd0);
      end
      if (words_sent >= next_drain) begin
        wait_for_drain();
        next_drain = words_sent + 400;
      end
    end
  endtask

  // result side: random stalls with calm stretches
  initial begin
    int unsigned stall;
    int unsigned words_taken;
    bit calm;
    words_taken = 0;
    calm = 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_readout(out_data);
      words_taken++;
      if (words_taken % 50 == 0) calm = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    int unsigned waited;
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    send_directed();
    wait_for_drain();
    send_random();
    in_valid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (sb.pending() != 0 && waited < DRAIN_LIMIT);
    repeat (10) @(posedge clk);
    if (sb.pending() != 0) sb.report("words never returned", 0, sb.pending());
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
